// ===== hw/rtl/pfb_pkg.sv =====
`timescale 1ns / 1ps

package pfb_pkg;

	localparam logic [7:0]  BYTE_START   = 8'h7E;
	localparam logic [7:0]  BYTE_VERSION = 8'h01;
	localparam logic [7:0]  BYTE_ZERO    = 8'h00;
	localparam logic [7:0]  BYTE_STOP    = 8'h7F;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_MSB      = 16'h8000;

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TOPIC = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_START,
		ST_VERSION,
		ST_ID_HI,
		ST_ID_LO,
		ST_ZERO,
		ST_TOPIC_LEN,
		ST_DATA,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_CRC_HI,
		ST_CRC_LO,
		ST_STOP
	} step_t;

	typedef struct packed {
		logic       op;
		logic [7:0] topic_length;
		logic [7:0] body_length;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic        hdr;
		logic [15:0] msg_id;
		logic [7:0]  topic_cnt;
		logic [7:0]  body_len;
		logic [7:0]  data;
		logic        do_len;
		logic        do_close;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/pfb_front.sv =====
`timescale 1ns / 1ps

module pfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pfb_pkg::in_item_t in_item,
	output logic              push_valid,
	input  logic              push_ready,
	output pfb_pkg::cmd_t     push_cmd
);

	pfb_pkg::phase_t phase_q, phase_d;
	logic [7:0]      topic_left_q, topic_left_d;
	logic [7:0]      body_left_q, body_left_d;
	logic [15:0]     msg_id_q, msg_id_d;
	logic            accept;
	logic [7:0]      dec_topic;
	logic [7:0]      dec_body;

	assign in_ready  = push_ready;
	assign accept    = in_valid & push_ready;
	assign dec_topic = topic_left_q - 8'd1;
	assign dec_body  = body_left_q - 8'd1;

	always_comb begin
		phase_d          = phase_q;
		topic_left_d     = topic_left_q;
		body_left_d      = body_left_q;
		msg_id_d         = msg_id_q;
		push_valid       = 1'b0;
		push_cmd.hdr     = 1'b0;
		push_cmd.msg_id  = msg_id_q;
		push_cmd.topic_cnt = in_item.topic_length;
		push_cmd.body_len  = body_left_q;
		push_cmd.data      = in_item.data_byte;
		push_cmd.do_len    = 1'b0;
		push_cmd.do_close  = 1'b0;
		if (in_item.op == pfb_pkg::OP_HEADER) begin
			push_valid        = in_valid;
			push_cmd.hdr      = 1'b1;
			push_cmd.body_len = in_item.body_length;
			topic_left_d      = in_item.topic_length;
			body_left_d       = in_item.body_length;
			msg_id_d          = msg_id_q + 16'd1;
			if (in_item.topic_length == 8'd0) begin
				push_cmd.do_len   = 1'b1;
				push_cmd.do_close = (in_item.body_length == 8'd0);
				phase_d = (in_item.body_length == 8'd0) ? pfb_pkg::PH_IDLE : pfb_pkg::PH_BODY;
			end else begin
				phase_d = pfb_pkg::PH_TOPIC;
			end
		end else begin
			unique case (phase_q)
				pfb_pkg::PH_TOPIC: begin
					push_valid   = in_valid;
					topic_left_d = dec_topic;
					if (dec_topic == 8'd0) begin
						push_cmd.do_len   = 1'b1;
						push_cmd.do_close = (body_left_q == 8'd0);
						phase_d = (body_left_q == 8'd0) ? pfb_pkg::PH_IDLE : pfb_pkg::PH_BODY;
					end
				end
				pfb_pkg::PH_BODY: begin
					push_valid  = in_valid;
					body_left_d = dec_body;
					if (dec_body == 8'd0) begin
						push_cmd.do_close = 1'b1;
						phase_d = pfb_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_d = pfb_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= pfb_pkg::PH_IDLE;
			topic_left_q <= 8'd0;
			body_left_q  <= 8'd0;
			msg_id_q     <= 16'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			topic_left_q <= topic_left_d;
			body_left_q  <= body_left_d;
			msg_id_q     <= msg_id_d;
		end
	end

endmodule

// ===== hw/rtl/pfb_queue.sv =====
`timescale 1ns / 1ps

module pfb_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pfb_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output pfb_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfb_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/pfb_back.sv =====
`timescale 1ns / 1ps

module pfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  pfb_pkg::cmd_t      pop_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output pfb_pkg::out_item_t out_item
);

	pfb_pkg::cmd_t      cmd_q;
	pfb_pkg::step_t     step_q, step_d;
	logic               busy_q;
	logic [15:0]        crc_q, crc_d;
	pfb_pkg::out_item_t out_q, out_d;
	logic               out_valid_q;
	logic               adv;
	logic               last;
	logic               load;

	assign adv       = busy_q & (~out_valid_q | out_ready);
	assign pop_ready = ~busy_q | (adv & last);
	assign load      = pop_valid & pop_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		step_d          = step_q;
		last            = 1'b0;
		out_d.frame_end = 1'b0;
		out_d.out_byte  = pfb_pkg::BYTE_ZERO;
		crc_d           = crc_q;
		unique case (step_q)
			pfb_pkg::ST_START: begin
				out_d.out_byte = pfb_pkg::BYTE_START;
				crc_d          = pfb_pkg::CRC_INIT;
				step_d         = pfb_pkg::ST_VERSION;
			end
			pfb_pkg::ST_VERSION: begin
				out_d.out_byte = pfb_pkg::BYTE_VERSION;
				step_d         = pfb_pkg::ST_ID_HI;
			end
			pfb_pkg::ST_ID_HI: begin
				out_d.out_byte = cmd_q.msg_id[15:8];
				step_d         = pfb_pkg::ST_ID_LO;
			end
			pfb_pkg::ST_ID_LO: begin
				out_d.out_byte = cmd_q.msg_id[7:0];
				step_d         = pfb_pkg::ST_ZERO;
			end
			pfb_pkg::ST_ZERO: begin
				out_d.out_byte = pfb_pkg::BYTE_ZERO;
				step_d         = pfb_pkg::ST_TOPIC_LEN;
			end
			pfb_pkg::ST_TOPIC_LEN: begin
				out_d.out_byte = cmd_q.topic_cnt;
				step_d         = pfb_pkg::ST_LEN_HI;
				last           = ~cmd_q.do_len;
			end
			pfb_pkg::ST_DATA: begin
				out_d.out_byte = cmd_q.data;
				step_d = cmd_q.do_len ? pfb_pkg::ST_LEN_HI : pfb_pkg::ST_CRC_HI;
				last   = ~cmd_q.do_len & ~cmd_q.do_close;
			end
			pfb_pkg::ST_LEN_HI: begin
				out_d.out_byte = pfb_pkg::BYTE_ZERO;
				step_d         = pfb_pkg::ST_LEN_LO;
			end
			pfb_pkg::ST_LEN_LO: begin
				out_d.out_byte = cmd_q.body_len;
				step_d         = pfb_pkg::ST_CRC_HI;
				last           = ~cmd_q.do_close;
			end
			pfb_pkg::ST_CRC_HI: begin
				out_d.out_byte = crc_q[15:8];
				step_d         = pfb_pkg::ST_CRC_LO;
			end
			pfb_pkg::ST_CRC_LO: begin
				out_d.out_byte = crc_q[7:0];
				step_d         = pfb_pkg::ST_STOP;
			end
			pfb_pkg::ST_STOP: begin
				out_d.out_byte  = pfb_pkg::BYTE_STOP;
				out_d.frame_end = 1'b1;
				step_d          = pfb_pkg::ST_START;
				last            = 1'b1;
			end
			default: begin
				step_d = pfb_pkg::ST_START;
				last   = 1'b1;
			end
		endcase
		if (step_q != pfb_pkg::ST_START && step_q != pfb_pkg::ST_CRC_HI &&
		    step_q != pfb_pkg::ST_CRC_LO && step_q != pfb_pkg::ST_STOP) begin
			crc_d = pfb_pkg::crc_byte(crc_q, out_d.out_byte);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= pop_cmd;
		end
		if (adv) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= pfb_pkg::ST_START;
			crc_q       <= pfb_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				crc_q       <= crc_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= 1'b1;
				step_q <= pop_cmd.hdr ? pfb_pkg::ST_START : pfb_pkg::ST_DATA;
			end else if (adv && last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				step_q <= step_d;
			end
		end
	end

endmodule

// ===== hw/rtl/publish_frame_builder_crc16.sv =====
`timescale 1ns / 1ps
// An accepted item passes the command queue and the back command and output registers.
// Back sequencer: one output byte per cycle while busy and out_ready allows; a data item
// gives 1 byte (up to 6 when it ends the topic or closes the frame), a header 6 to 11.
// Input is taken while the command queue between front and back has room.
// Reset: no frame open, message id 0, CRC 0xFFFF, queue and output register empty.

module publish_frame_builder_crc16 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pfb_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output pfb_pkg::out_item_t out_item
);

	logic          push_valid;
	logic          push_ready;
	pfb_pkg::cmd_t push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	pfb_pkg::cmd_t pop_cmd;

	pfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	pfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	pfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/sv/publish_frame_builder_crc16_test.sv =====
`timescale 1ns / 1ps

module publish_frame_builder_crc16_test;

	import pfb_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 96;
	localparam int DRAIN_CYCLES  = 16;
	localparam int MAX_PRINTED   = 40;

	class frame_scoreboard;
		phase_t    phase;
		bit [7:0]  topic_left;
		bit [7:0]  body_left;
		bit [15:0] crc;
		bit [15:0] msg_id;
		out_item_t frame_bytes[$];
		int        errors;
		int        bytes_checked;
		int        frames_closed;
		int        ignored;

		function new();
			phase = PH_IDLE;
			topic_left = 8'h00;
			body_left = 8'h00;
			crc = CRC_INIT;
			msg_id = 16'h0000;
			errors = 0;
			bytes_checked = 0;
			frames_closed = 0;
			ignored = 0;
		endfunction

		function bit [15:0] crc_step(input bit [15:0] c, input bit [7:0] b);
			c = c ^ {b, 8'h00};
			for (int i = 0; i < 8; i++) begin
				if ((c & CRC_MSB) != 16'h0000) begin
					c = {c[14:0], 1'b0} ^ CRC_POLY;
				end else begin
					c = {c[14:0], 1'b0};
				end
			end
			return c;
		endfunction

		function void push(input bit [7:0] b, input bit last);
			out_item_t o;
			o.out_byte = b;
			o.frame_end = last;
			frame_bytes.push_back(o);
		endfunction

		function void push_crc(input bit [7:0] b);
			push(b, 1'b0);
			crc = crc_step(crc, b);
		endfunction

		function void close_frame();
			push(crc[15:8], 1'b0);
			push(crc[7:0], 1'b0);
			push(BYTE_STOP, 1'b1);
			phase = PH_IDLE;
			crc = CRC_INIT;
			frames_closed++;
		endfunction

		function void finish_topic();
			push_crc(BYTE_ZERO);
			push_crc(body_left);
			if (body_left == 8'h00) begin
				close_frame();
			end else begin
				phase = PH_BODY;
			end
		endfunction

		function int note_item(input in_item_t it);
			int size_prior;
			size_prior = frame_bytes.size();
			if (it.op == OP_HEADER) begin
				crc = CRC_INIT;
				topic_left = it.topic_length;
				body_left = it.body_length;
				push(BYTE_START, 1'b0);
				push_crc(BYTE_VERSION);
				push_crc(msg_id[15:8]);
				push_crc(msg_id[7:0]);
				msg_id = msg_id + 16'h0001;
				push_crc(BYTE_ZERO);
				push_crc(it.topic_length);
				if (it.topic_length == 8'h00) begin
					finish_topic();
				end else begin
					phase = PH_TOPIC;
				end
			end else begin
				case (phase)
					PH_TOPIC: begin
						push_crc(it.data_byte);
						topic_left = topic_left - 8'h01;
						if (topic_left == 8'h00) begin
							finish_topic();
						end
					end
					PH_BODY: begin
						push_crc(it.data_byte);
						body_left = body_left - 8'h01;
						if (body_left == 8'h00) begin
							close_frame();
						end
					end
					default: begin
						ignored++;
					end
				endcase
			end
			return frame_bytes.size() - size_prior;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= MAX_PRINTED) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endtask

		task check_byte(input out_item_t got);
			out_item_t want;
			if (frame_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h end %0b", got.out_byte, got.frame_end));
			end else begin
				want = frame_bytes.pop_front();
				bytes_checked++;
				if (got.out_byte !== want.out_byte) begin
					report($sformatf("byte %0d: out_byte %02h, want %02h",
						bytes_checked, got.out_byte, want.out_byte));
				end
				if (got.frame_end !== want.frame_end) begin
					report($sformatf("byte %0d: frame_end %0b, want %0b",
						bytes_checked, got.frame_end, want.frame_end));
				end
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;

	frame_scoreboard sb = new();

	bit hold_req;
	int burst_left;
	int items_sent;

	publish_frame_builder_crc16 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_byte(out_item);
		end
	end

	initial begin : receiver
		int tick;
		int mode;
		int hold_left;
		tick = 0;
		mode = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 64 == 0) begin
				mode = $urandom_range(0, 3);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((tick % 8) < 5);
				endcase
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d bytes still due", cycles, sb.frame_bytes.size());
		$display("** publish_frame_builder_crc16: FAILED **");
		$finish;
	end

	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		if (sb.note_item(it) != 0) begin
			items_sent++;
		end
	endtask

	task automatic send_header(input int tl, input int bl);
		in_item_t it;
		it.op = OP_HEADER;
		it.topic_length = 8'(tl);
		it.body_length = 8'(bl);
		it.data_byte = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic send_data(input int b);
		in_item_t it;
		it.op = OP_DATA;
		it.topic_length = 8'($urandom_range(0, 255));
		it.body_length = 8'($urandom_range(0, 255));
		it.data_byte = 8'(b);
		send_item(it);
	endtask

	task automatic send_frame(input int tl, input int bl, input int count);
		send_header(tl, bl);
		for (int i = 0; i < count; i++) begin
			send_data($urandom_range(0, 255));
		end
	endtask

	task automatic wait_for_stream_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.frame_bytes.size() != 0);
	endtask

	function automatic int pick_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
	endfunction

	initial begin : stimulus
		int directed_items;
		int tl;
		int bl;
		int kind;
		bit hold_done;
		bit pause_done;
		hold_req = 1'b0;
		burst_left = 0;
		items_sent = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_data(8'hFF);
		send_data(8'h00);
		send_header(0, 0);
		send_header(0, 1);
		send_data(8'hFF);
		send_header(1, 0);
		send_data(8'h00);
		send_header(2, 3);
		send_data(8'h80);
		send_data(8'h7F);
		send_data(8'h7E);
		send_data(8'h01);
		send_data(8'h55);
		send_header(255, 255);
		send_data(8'hAA);
		send_header(1, 3);
		send_data(8'h11);
		send_data(8'h22);
		send_header(0, 2);
		send_data(8'hFF);
		send_data(8'h00);
		send_data(8'h33);
		wait_for_stream_idle();
		directed_items = items_sent;

		while (items_sent - directed_items < RANDOM_ITEMS) begin
			if (!hold_done && items_sent - directed_items >= 40) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (!pause_done && items_sent - directed_items >= 80) begin
				wait_for_stream_idle();
				pause_done = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 3)) send_data($urandom_range(0, 255));
			end else if (kind == 1) begin
				tl = $urandom_range(0, 255);
				bl = $urandom_range(0, 255);
				send_frame(tl, bl, $urandom_range(0, 4));
			end else begin
				tl = pick_len();
				bl = pick_len();
				send_frame(tl, bl, tl + bl);
			end
		end

		wait_for_stream_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.frame_bytes.size() != 0) begin
			sb.report($sformatf("%0d bytes never arrived", sb.frame_bytes.size()));
		end
		$display("Run covered %0d items with output, %0d stray data bytes, %0d closed frames,",
			items_sent, sb.ignored, sb.frames_closed);
		$display("%0d output bytes checked under input gaps and output stalls.",
			sb.bytes_checked);
		if (sb.errors == 0) begin
			$display("** publish_frame_builder_crc16: PASSED **");
		end else begin
			$display("** publish_frame_builder_crc16: FAILED **");
		end
		$finish;
	end

endmodule
